// ----- rtl/ssd_pkg.sv -----
// Shared types and constants of the slice stream deframer.
// No dependencies; every other file but ssd_div imports this package.
`default_nettype none

package ssd_pkg;

    // Window geometry.
    localparam int WORD_BYTES = 8;
    localparam int BUF_DEPTH  = 16;

    // Stream marker bytes.
    localparam logic [7:0] BYTE_55 = 8'h55;
    localparam logic [7:0] BYTE_AA = 8'haa;
    localparam logic [7:0] BYTE_FF = 8'hff;

    // Register reset values and indexes.
    localparam logic [7:0]  RATE_RESET      = 8'd12;
    localparam logic [63:0] TIME_MASK_RESET = 64'h0000_00ff_ffff_ffff;
    localparam logic        REG_CLOCK_RATE  = 1'b0;
    localparam logic        REG_TIME_MASK   = 1'b1;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    // 2^26 modulo one second in microseconds, used to fold high bits down.
    localparam logic [16:0] USEC_FOLD    = 17'd108864;

    // Result kinds.
    localparam logic [2:0] KIND_SLICE        = 3'd0;
    localparam logic [2:0] KIND_BLANK        = 3'd1;
    localparam logic [2:0] KIND_SYNC_KEPT    = 3'd2;
    localparam logic [2:0] KIND_SYNC_DISCARD = 3'd3;
    localparam logic [2:0] KIND_OVERLOAD     = 3'd4;
    localparam logic [2:0] KIND_PART55       = 3'd5;
    localparam logic [2:0] KIND_PARTAA       = 3'd6;

    // Window scan outcomes.
    localparam logic [1:0] ST_WAIT  = 2'd0;
    localparam logic [1:0] ST_PLAIN = 2'd1;
    localparam logic [1:0] ST_WORD  = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        record_start;
        logic [62:0] record_time_us;
    } t_in;

    typedef struct packed {
        logic [2:0]  word_kind;
        logic [63:0] word_data;
        logic [63:0] time_us;
        logic [62:0] particle_time_us;
        logic [19:0] dead_time_add_us;
        logic        misaligned;
        logic [2:0]  suspect_bytes;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic take;
        logic rec;
        logic push;
        logic cls;
        logic div_start;
        logic div_mod;
        logic time_ld;
        logic dead_ld;
        logic emit;
        logic drop;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] st;
        logic       slice_ok;
        logic       timed;
        logic       need_dead;
        logic       can_push;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/slice_stream_deframer_core.sv -----
// A byte ending a slice passes through the record, push, classify and decode states to emit;
// sync and overload words also wait on the 64-step divider, and overload words that need
// a dead-time correction then wait on the modulo-one-second unit before emit.
// Bytes that give no result return to idle from the push or the decode state.
// One byte is in work at a time; a finished result waits in the output register.
// Reset (i_rst_n low, synchronous) empties the window, drops the next record.
`default_nettype none

module slice_stream_deframer_core
    import ssd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    ssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Window, arithmetic and result register.
    ssd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- rtl/ssd_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its ports.
`default_nettype none

module ssd_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [19:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quotient
);

    localparam int STEPS = 64;
    localparam int CW    = $clog2(STEPS + 1);

    logic [63:0]   r_q;
    logic [19:0]   r_rem;
    logic [19:0]   r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [20:0]   rem_sh;
    logic          ge;
    logic [20:0]   n_rem;

    // One restoring step.
    always_comb begin
        rem_sh = {r_rem, r_q[63]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_rem  = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    // Step counter and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_cnt  <= CW'(STEPS);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], ge};
            r_rem <= n_rem[19:0];
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;

endmodule

`default_nettype wire

// ----- rtl/ssd_datapath.sv -----
// Datapath of the deframer: byte window, scan, time arithmetic, result register.
// Depends on ssd_pkg and ssd_div.
`default_nettype none

module ssd_datapath
    import ssd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_in         i_in_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_out_stall,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output t_out             o_out_data
);

    typedef struct packed {
        logic [1:0] st;
        logic [2:0] pos;
        logic [2:0] strays;
        logic       slice_ok;
        logic [2:0] kind;
    } t_scan;

    typedef logic [7:0] t_byte;

    // Architectural state.
    logic [7:0]  r_rate;
    logic [63:0] r_mask;
    t_byte       r_buf [BUF_DEPTH];
    logic [4:0]  r_fill;
    logic [2:0]  r_off;
    logic [63:0] r_last;
    logic [63:0] r_first;
    logic        r_first_v;
    logic [62:0] r_prev;
    logic [62:0] r_base;
    logic        r_dropped;
    t_in         r_in;

    // Per-beat working registers.
    logic [1:0]  r_st;
    logic [2:0]  r_kind;
    logic        r_slice_ok;
    logic [63:0] r_word;
    logic [2:0]  r_strays;
    logic        r_mis;
    logic [3:0]  r_dropk;
    logic [63:0] r_t;
    logic [62:0] r_pt;
    logic [19:0] r_dead;
    t_out        r_out;
    logic        r_out_valid;

    // Modulo-one-second unit.
    logic [63:0] r_mx;
    logic [2:0]  r_msh;
    logic        r_mbusy;
    logic        r_mdone;

    // Combinational helpers.
    t_scan       scan;
    logic [3:0]  rec_k;
    logic [3:0]  drop_k;
    t_byte       shifted [BUF_DEPTH];
    logic [4:0]  fill_new;
    logic [63:0] word_at;
    logic        timed;
    logic        div_go;
    logic        mod_go;
    logic        div_done;
    logic [63:0] div_q;
    logic [63:0] div_a;
    logic [19:0] div_b;
    logic [63:0] first_eff;
    logic [63:0] dt;
    logic [54:0] fold_p;
    logic [63:0] fold_x;
    logic [63:0] sub_c;
    t_out        out_next;

    // Scan of the window: classifies from the first buffered byte onwards.
    function automatic t_scan scan_window(input t_byte b[BUF_DEPTH], input logic [4:0] fill);
        t_scan s;
        logic  done;
        t_byte b0;
        t_byte b1;
        t_byte b2;
        s.st       = ST_PLAIN;
        s.pos      = '0;
        s.strays   = '0;
        s.slice_ok = 1'b1;
        s.kind     = KIND_SLICE;
        done       = 1'b0;
        if (int'(fill) < WORD_BYTES) begin
            s.st = ST_WAIT;
            done = 1'b1;
        end
        for (int q = 0; q < WORD_BYTES; q++) begin
            b0 = b[q];
            b1 = b[q + 1];
            b2 = b[q + 2];
            if (!done && (b0 == BYTE_55 || b0 == BYTE_AA)) begin
                if (int'(fill) < q + WORD_BYTES) begin
                    s.st  = ST_WAIT;
                    s.pos = 3'(q);
                    done  = 1'b1;
                end else if (b0 == BYTE_55 && b1 == BYTE_55) begin
                    s.st   = ST_WORD;
                    s.pos  = 3'(q);
                    s.kind = (b2 == BYTE_AA) ? KIND_OVERLOAD : KIND_PART55;
                    done   = 1'b1;
                end else if (b0 == BYTE_AA && b1 == BYTE_AA) begin
                    s.st  = ST_WORD;
                    s.pos = 3'(q);
                    if (b2 == BYTE_AA) begin
                        s.kind = (q == 0) ? KIND_SYNC_KEPT : KIND_SYNC_DISCARD;
                    end else begin
                        s.kind = KIND_PARTAA;
                    end
                    done = 1'b1;
                end else begin
                    if (b0 == BYTE_AA) begin
                        s.slice_ok = 1'b0;
                    end
                    s.strays = s.strays + 3'd1;
                end
            end
        end
        return s;
    endfunction

    always_comb begin
        scan = scan_window(r_buf, r_fill);

        // Bytes discarded at a record boundary: those before a waiting marker.
        rec_k = (!r_dropped && scan.st == ST_WAIT && r_fill >= 5'(WORD_BYTES))
              ? {1'b0, scan.pos} : 4'd0;
        drop_k   = i_cmd.rec ? rec_k : r_dropk;
        fill_new = ({1'b0, drop_k} > r_fill) ? 5'd0 : (r_fill - {1'b0, drop_k});
        for (int i = 0; i < BUF_DEPTH; i++) begin
            shifted[i] = (i + int'(drop_k) < BUF_DEPTH) ? r_buf[4'(i + int'(drop_k))] : r_buf[i];
        end

        // Eight bytes from the scan position, first byte most significant.
        word_at = '0;
        for (int i = 0; i < WORD_BYTES; i++) begin
            word_at = {word_at[55:0], r_buf[4'({1'b0, scan.pos}) + 4'(i)]};
        end

        timed = (r_kind == KIND_OVERLOAD) || (r_kind == KIND_SYNC_KEPT)
             || (r_kind == KIND_SYNC_DISCARD);

        // Divider takes the time word by clock rate; the modulo unit takes a second.
        div_go = i_cmd.div_start && !i_cmd.div_mod;
        mod_go = i_cmd.div_start && i_cmd.div_mod;
        div_a  = r_word & r_mask;
        div_b  = {12'd0, (r_rate == 8'd0) ? 8'd1 : r_rate};

        // Folding step: x = hi * 2^26 + lo is congruent to hi * (2^26 mod 1e6) + lo.
        fold_p = {17'd0, r_mx[63:26]} * {38'd0, USEC_FOLD};
        fold_x = {9'd0, fold_p} + {38'd0, r_mx[25:0]};
        sub_c  = {44'd0, USEC_PER_SEC} << r_msh;

        first_eff = r_first_v ? r_first : div_q;
        dt        = r_t - r_last;

        out_next.word_kind        = r_kind;
        out_next.word_data        = r_word;
        out_next.time_us          = r_t;
        out_next.particle_time_us = r_pt;
        out_next.dead_time_add_us = r_dead;
        out_next.misaligned       = r_mis && timed;
        out_next.suspect_bytes    = r_strays;
    end

    ssd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_go),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_done      (div_done),
        .o_quotient  (div_q)
    );

    // Particle time modulo one second: folds while wide, then compare and subtract.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
        end else if (mod_go) begin
            r_mx    <= {1'b0, r_pt};
            r_msh   <= 3'd6;
            r_mbusy <= 1'b1;
            r_mdone <= 1'b0;
        end else if (r_mbusy) begin
            if (r_mx[63:26] != '0) begin
                r_mx <= fold_x;
            end else begin
                if (r_mx >= sub_c) begin
                    r_mx <= r_mx - sub_c;
                end
                r_msh <= r_msh - 3'd1;
                if (r_msh == 3'd0) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end else begin
            r_mdone <= 1'b0;
        end
    end

    // Window buffer contents; no reset, read only below the fill count.
    always_ff @(posedge i_clk) begin
        if ((i_cmd.rec && r_in.record_start) || i_cmd.drop) begin
            r_buf <= shifted;
        end else if (i_cmd.push) begin
            r_buf[r_fill[3:0]] <= r_in.data_byte;
        end
    end

    // Control state, configuration and record bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_mask      <= TIME_MASK_RESET;
            r_fill      <= '0;
            r_off       <= '0;
            r_last      <= '0;
            r_first     <= '0;
            r_first_v   <= 1'b0;
            r_prev      <= '0;
            r_base      <= '0;
            r_dropped   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CLOCK_RATE: r_rate <= i_cfg_data[7:0];
                    REG_TIME_MASK:  r_mask <= i_cfg_data;
                    default:        r_rate <= r_rate;
                endcase
            end

            if (i_cmd.rec && r_in.record_start) begin
                r_fill    <= fill_new;
                r_off     <= 3'(5'd0 - fill_new);
                r_base    <= r_prev;
                r_prev    <= r_in.record_time_us;
                r_dropped <= (r_prev == '0);
                r_first_v <= 1'b0;
                r_first   <= '0;
            end else if (i_cmd.push) begin
                r_fill <= r_fill + 5'd1;
            end else if (i_cmd.drop) begin
                r_fill <= fill_new;
                r_off  <= r_off + 3'(drop_k);
            end

            if (i_cmd.time_ld && !r_first_v) begin
                r_first   <= div_q;
                r_first_v <= 1'b1;
            end

            if (i_cmd.emit && timed) begin
                r_last <= r_t;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers for the beat in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_in <= i_in_data;
        end
        if (i_cmd.cls) begin
            r_st       <= scan.st;
            r_slice_ok <= scan.slice_ok;
            r_word     <= word_at;
            r_strays   <= scan.strays;
            r_t        <= '0;
            r_pt       <= '0;
            r_dead     <= '0;
            r_mis      <= (r_off + scan.pos) != 3'd0;
            if (scan.st == ST_PLAIN) begin
                r_kind  <= (word_at == '1) ? KIND_BLANK : KIND_SLICE;
                r_dropk <= 4'(WORD_BYTES);
            end else begin
                r_kind  <= scan.kind;
                r_dropk <= {1'b0, scan.pos} + 4'(WORD_BYTES);
            end
        end
        if (i_cmd.time_ld) begin
            r_t  <= div_q;
            r_pt <= r_base + 63'(div_q - first_eff);
        end
        if (i_cmd.dead_ld) begin
            r_dead <= (dt < r_mx) ? dt[19:0] : r_mx[19:0];
        end
        if (i_cmd.emit) begin
            r_out <= out_next;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_sts.st        = r_st;
        o_sts.slice_ok  = r_slice_ok;
        o_sts.timed     = timed;
        o_sts.need_dead = (r_kind == KIND_OVERLOAD) && (r_t > r_last);
        o_sts.can_push  = !r_dropped && !r_fill[4];
        o_sts.div_done  = div_done || r_mdone;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The window never holds more than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'(BUF_DEPTH))
        else $error("window fill beyond depth");

    // A result is loaded only into a free output register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten");

    // A loaded result is offered on the next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("result lost");

    // A byte is never pushed into a full window.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !r_fill[4])
        else $error("push into full window");

endmodule

`default_nettype wire

// ----- rtl/ssd_ctrl.sv -----
// Controller of the deframer: sequences one beat through scan, division and output.
// Depends on ssd_pkg.
`default_nettype none

module ssd_ctrl
    import ssd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_REC, S_PUSH, S_CLS, S_DEC, S_DIV, S_TIME, S_CHK, S_MOD, S_DEAD, S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_REC;
                end
            end
            S_REC: begin
                o_cmd.rec = 1'b1;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                if (i_sts.can_push) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_CLS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CLS: begin
                o_cmd.cls = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                case (i_sts.st)
                    ST_PLAIN: begin
                        if (i_sts.slice_ok) begin
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.drop = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    ST_WORD: begin
                        if (i_sts.timed) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_TIME;
                end
            end
            S_TIME: begin
                o_cmd.time_ld = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_sts.need_dead) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_mod   = 1'b1;
                    n_state         = S_MOD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_MOD: begin
                if (i_sts.div_done) begin
                    n_state = S_DEAD;
                end
            end
            S_DEAD: begin
                o_cmd.dead_ld = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.drop = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // The two divisions are started only from their own states.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> (r_state == S_DEC || r_state == S_CHK))
        else $error("division started out of sequence");

    // A new beat is taken only when the previous one is finished.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> (r_state == S_REC))
        else $error("beat taken outside idle");

    // Every emitted result also retires its bytes.
    a_emit_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> o_cmd.drop)
        else $error("result without window advance");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench of the slice stream deframer core.
// Depends on ssd_pkg and slice_stream_deframer_core; a built-in predictor checks every beat.
`timescale 1ns / 100ps

module tb;
    import ssd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 160;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;

    slice_stream_deframer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Beats waiting to be sent and words the deframer should produce.
    t_in  byte_queue[$];
    t_out word_queue[$];
    int   errors;
    int unsigned cycles;
    bit   in_taken;

    // Predictor state: the window, its alignment and the timing history.
    logic [7:0]  win[16];
    int          win_fill;
    int          win_offset;
    logic [63:0] last_tw;
    logic [63:0] first_tw;
    bit          first_seen;
    logic [62:0] prev_rec_time;
    logic [62:0] base_time;
    bit          rec_dropped;
    logic [7:0]  rate_mhz;
    logic [63:0] tw_mask;

    // Record assembly state for the stimulus.
    bit          start_pending;
    logic [62:0] start_time;

    function automatic logic [63:0] window_word(int pos);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < WORD_BYTES; i++) w = {w[55:0], win[(pos + i) & 15]};
        return w;
    endfunction

    function automatic void consume(int k);
        if (k > win_fill) k = win_fill;
        if (k == 0) return;
        for (int i = 0; i < 16 - k; i++) win[i] = win[i + k];
        win_fill -= k;
        win_offset = (win_offset + k) & 7;
    endfunction

    // Scans the window for marker words and stray marker bytes.
    function automatic void scan_window(output logic [1:0] st, output int pos,
                                        output int strays, output bit slice_ok,
                                        output logic [2:0] kind);
        logic [7:0] b, b1, b2;
        pos = 0;
        strays = 0;
        slice_ok = 1'b1;
        kind = KIND_SLICE;
        st = ST_PLAIN;
        if (win_fill < WORD_BYTES) begin
            st = ST_WAIT;
            return;
        end
        for (int q = 0; q < WORD_BYTES; q++) begin
            b = win[q];
            if (b == BYTE_55 || b == BYTE_AA) begin
                pos = q;
                if (win_fill < q + WORD_BYTES) begin
                    st = ST_WAIT;
                    return;
                end
                b1 = win[q + 1];
                b2 = win[q + 2];
                st = ST_WORD;
                if (b == BYTE_55) begin
                    if (b1 == BYTE_55 && b2 == BYTE_AA) begin
                        kind = KIND_OVERLOAD;
                        return;
                    end
                    if (b1 == BYTE_55) begin
                        kind = KIND_PART55;
                        return;
                    end
                end else begin
                    if (b1 == BYTE_AA && b2 == BYTE_AA) begin
                        kind = (q == 0) ? KIND_SYNC_KEPT : KIND_SYNC_DISCARD;
                        return;
                    end
                    if (b1 == BYTE_AA) begin
                        kind = KIND_PARTAA;
                        return;
                    end
                    slice_ok = 1'b0;
                end
                st = ST_PLAIN;
                strays++;
            end
        end
        pos = 0;
    endfunction

    // Works out the word, if any, that one accepted beat completes.
    function automatic void predict_word(t_in it);
        logic [1:0]  st;
        int          pos, strays;
        bit          ok;
        logic [2:0]  kind;
        logic [63:0] w, t, pt, usec, dt, div;
        t_out        r;
        if (it.record_start) begin
            if (!rec_dropped) begin
                scan_window(st, pos, strays, ok, kind);
                if (st == ST_WAIT && win_fill >= WORD_BYTES) consume(pos);
            end
            base_time = prev_rec_time;
            prev_rec_time = it.record_time_us;
            rec_dropped = (base_time == 0);
            first_seen = 1'b0;
            first_tw = '0;
            win_offset = (8 - (win_fill & 7)) & 7;
        end
        if (rec_dropped || win_fill >= 16) return;
        win[win_fill] = it.data_byte;
        win_fill++;
        scan_window(st, pos, strays, ok, kind);
        if (st == ST_WAIT) return;
        r = '0;
        r.suspect_bytes = strays[2:0];
        if (st == ST_PLAIN) begin
            w = window_word(0);
            consume(WORD_BYTES);
            if (!ok) return;
            r.word_kind = (w == '1) ? KIND_BLANK : KIND_SLICE;
            r.word_data = w;
            word_queue = {word_queue, r};
            return;
        end
        r.word_kind = kind;
        r.word_data = window_word(pos);
        if (kind == KIND_OVERLOAD || kind == KIND_SYNC_KEPT || kind == KIND_SYNC_DISCARD) begin
            div = (rate_mhz == 0) ? 64'd1 : {56'd0, rate_mhz};
            t = (r.word_data & tw_mask) / div;
            if (!first_seen) begin
                first_tw = t;
                first_seen = 1'b1;
            end
            pt = {1'b0, base_time} + (t - first_tw);
            pt[63] = 1'b0;
            r.time_us = t;
            r.particle_time_us = pt[62:0];
            r.misaligned = (((win_offset + pos) & 7) != 0);
            if (kind == KIND_OVERLOAD && t > last_tw) begin
                usec = pt % 64'd1000000;
                dt = t - last_tw;
                r.dead_time_add_us = (dt < usec) ? dt[19:0] : usec[19:0];
            end
            last_tw = t;
        end
        consume(pos + WORD_BYTES);
        word_queue = {word_queue, r};
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
        errors++;
    endtask

    // Sampling at the rising edge: accepted bytes feed the predictor, words are checked.
    always @(posedge i_clk) begin
        t_out want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL slice_stream_deframer_core");
            $finish;
        end
        in_taken = i_in_valid && !o_in_stall;
        if (in_taken) predict_word(i_in_data);
        if (o_out_valid && !i_out_stall) begin
            if (word_queue.size() == 0) begin
                report("unexpected word", o_out_data.word_data, '0);
            end else begin
                want = word_queue.pop_front();
                if (o_out_data.word_kind !== want.word_kind)
                    report("word_kind", 64'(o_out_data.word_kind), 64'(want.word_kind));
                if (o_out_data.word_data !== want.word_data)
                    report("word_data", o_out_data.word_data, want.word_data);
                if (o_out_data.time_us !== want.time_us)
                    report("time_us", o_out_data.time_us, want.time_us);
                if (o_out_data.particle_time_us !== want.particle_time_us)
                    report("particle_time_us", 64'(o_out_data.particle_time_us),
                           64'(want.particle_time_us));
                if (o_out_data.dead_time_add_us !== want.dead_time_add_us)
                    report("dead_time_add_us", 64'(o_out_data.dead_time_add_us),
                           64'(want.dead_time_add_us));
                if (o_out_data.misaligned !== want.misaligned)
                    report("misaligned", 64'(o_out_data.misaligned), 64'(want.misaligned));
                if (o_out_data.suspect_bytes !== want.suspect_bytes)
                    report("suspect_bytes", 64'(o_out_data.suspect_bytes),
                           64'(want.suspect_bytes));
            end
        end
    end

    // Byte driver: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= byte_queue.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(30, 0);
                    gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 0);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result stall pattern: runs of no stall, random stall and periodic stall.
    int stall_mode;
    int stall_count;
    always @(negedge i_clk) begin
        stall_count++;
        if (stall_count % 300 == 0) stall_mode = $urandom_range(2, 0);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(9, 0) < 4);
            default: i_out_stall <= ((stall_count % 7) < 3);
        endcase
    end

    task automatic put_byte(logic [7:0] b);
        t_in it;
        it.data_byte = b;
        it.record_start = start_pending;
        it.record_time_us = start_pending ? start_time : 63'({$urandom, $urandom});
        start_pending = 1'b0;
        byte_queue = {byte_queue, it};
    endtask

    task automatic open_record(logic [62:0] tag);
        start_pending = 1'b1;
        start_time = tag;
    endtask

    task automatic put_word(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        put_byte(b0);
        put_byte(b1);
        put_byte(b2);
        for (int i = 0; i < 5; i++) put_byte(8'($urandom));
    endtask

    // One record of random words: mostly well-formed, with some noise.
    task automatic put_record();
        int words;
        open_record(($urandom_range(30, 0) == 0) ? '0 : 63'({$urandom, $urandom}));
        words = $urandom_range(10, 3);
        for (int n = 0; n < words; n++) begin
            case ($urandom_range(11, 0))
                0, 1, 2: for (int i = 0; i < 8; i++) put_byte(8'($urandom));
                3:       for (int i = 0; i < 8; i++) put_byte(BYTE_FF);
                4, 5:    put_word(BYTE_AA, BYTE_AA, BYTE_AA);
                6, 7:    put_word(BYTE_55, BYTE_55, BYTE_AA);
                8:       put_word(BYTE_55, BYTE_55, 8'($urandom));
                9:       put_word(BYTE_AA, BYTE_AA, 8'($urandom));
                10:      put_byte($urandom_range(1, 0) ? BYTE_55 : BYTE_AA);
                default: repeat ($urandom_range(7, 1)) put_byte(8'($urandom));
            endcase
        end
    endtask

    // Waits until all beats are sent and all words checked, then lets the block settle.
    task automatic wait_idle();
        while (byte_queue.size() > 0 || i_in_valid || word_queue.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CLOCK_RATE) rate_mhz = value[7:0];
        else tw_mask = value;
    endtask

    initial begin
        logic [7:0]  rates[5];
        logic [63:0] masks[5];
        errors = 0;
        cycles = 0;
        in_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        stall_count = 0;
        start_pending = 1'b0;
        start_time = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_CLOCK_RATE;
        i_cfg_data = '0;
        for (int i = 0; i < 16; i++) win[i] = '0;
        win_fill = 0;
        win_offset = 0;
        last_tw = '0;
        first_tw = '0;
        first_seen = 1'b0;
        prev_rec_time = '0;
        base_time = '0;
        rec_dropped = 1'b1;
        rate_mhz = RATE_RESET;
        tw_mask = TIME_MASK_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a dropped first record, then a blank, an overload and a sync.
        open_record(63'd5);
        put_byte(8'h00);
        open_record(63'h7fff_ffff_ffff_ffff);
        for (int i = 0; i < 8; i++) put_byte(BYTE_FF);
        put_word(BYTE_55, BYTE_55, BYTE_AA);
        put_word(BYTE_AA, BYTE_AA, BYTE_AA);
        wait_idle();

        // Random records under several register settings, extremes included.
        rates = '{8'd12, 8'd1, 8'd255, 8'd0, 8'd0};
        masks = '{TIME_MASK_RESET, '1, '0, '1, '0};
        rates[4] = 8'($urandom_range(254, 2));
        masks[4] = {$urandom, $urandom};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                write_reg(REG_CLOCK_RATE, {56'd0, rates[ph]});
                write_reg(REG_TIME_MASK, masks[ph]);
            end
            while (byte_queue.size() < 165) put_record();
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASS slice_stream_deframer_core");
        end else begin
            $display("FAIL slice_stream_deframer_core");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ssd_pkg.sv
rtl/ssd_div.sv
rtl/ssd_datapath.sv
rtl/ssd_ctrl.sv
rtl/slice_stream_deframer_core.sv
tb/tb.sv
